// File: design/gtsp_pkg.sv
// ----------------------------------------------------------------------------
// gtsp_pkg
// Shared types, sizes and helper functions for the slot pool.
// ----------------------------------------------------------------------------
`default_nettype none

package gtsp_pkg;

    // Pool geometry and storage widths.
    localparam int SLOTS       = 64;
    localparam int GEN_WIDTH   = 32;
    localparam int COUNT_WIDTH = 32;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BUSY_W      = $clog2(SLOTS + 1);

    // Widths of the port fields.
    localparam int POOL_W      = 7;
    localparam int IN_SLOT_W   = 8;
    localparam int IN_GEN_W    = 32;
    localparam int OUT_SLOT_W  = 6;
    localparam int OUT_GEN_W   = 32;
    localparam int OUT_BUSY_W  = 7;
    localparam int OUT_COUNT_W = 32;

    // Width at which a stored tag and an offered generation are compared.
    localparam int CMP_W = (GEN_WIDTH > IN_GEN_W) ? GEN_WIDTH : IN_GEN_W;

    // Pool size after reset.
    localparam logic [POOL_W-1:0] POOL_RESET = POOL_W'(64);

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    // Outcome of one processed beat, seen by the slot map and the counters.
    typedef struct packed {
        logic              grant;
        logic              release_ok;
        logic              reject;
        logic [SLOT_W-1:0] idx;
    } t_slot_upd;

    // Result of the free-slot search.
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } t_free;

    // Lowest free slot whose index is below the pool size.
    function automatic t_free first_free(input logic [SLOTS-1:0] busy,
                                         input logic [POOL_W-1:0] pool);
        t_free res;
        res = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!busy[i] && (i < int'(pool))) begin
                res.found = 1'b1;
                res.idx   = SLOT_W'(i);
            end
        end
        return res;
    endfunction

    // Next generation tag: wraps at the tag width and never becomes zero.
    function automatic logic [GEN_WIDTH-1:0] next_tag(input logic [GEN_WIDTH-1:0] tag);
        logic [GEN_WIDTH-1:0] t;
        t = tag + GEN_WIDTH'(1);
        if (t == '0) begin
            t = GEN_WIDTH'(1);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// File: design/gtsp_ram.sv
// ----------------------------------------------------------------------------
// gtsp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gtsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; a read at the written address returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/gtsp_slot_map.sv
// ----------------------------------------------------------------------------
// gtsp_slot_map
// Busy bits and tag-written bits of every slot, with the free-slot search.
// ----------------------------------------------------------------------------
`default_nettype none

module gtsp_slot_map (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire gtsp_pkg::t_slot_upd              i_upd,
    input  wire logic [gtsp_pkg::POOL_W-1:0]      i_pool_size,
    output logic      [gtsp_pkg::SLOTS-1:0]       o_busy,
    output logic      [gtsp_pkg::SLOTS-1:0]       o_tag_vld_next,
    output gtsp_pkg::t_free                       o_free
);

    logic [gtsp_pkg::SLOTS-1:0] r_busy;
    logic [gtsp_pkg::SLOTS-1:0] n_busy;
    logic [gtsp_pkg::SLOTS-1:0] r_tag_vld;
    logic [gtsp_pkg::SLOTS-1:0] n_tag_vld;

    // Apply the outcome of the beat now being finished.
    always_comb begin
        n_busy    = r_busy;
        n_tag_vld = r_tag_vld;
        if (i_upd.grant) begin
            n_busy[i_upd.idx]    = 1'b1;
            n_tag_vld[i_upd.idx] = 1'b1;
        end
        if (i_upd.release_ok) begin
            n_busy[i_upd.idx] = 1'b0;
        end
    end

    // A tag that was never written reads as zero, so reset only clears these bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= '0;
            r_tag_vld <= '0;
        end else begin
            r_busy    <= n_busy;
            r_tag_vld <= n_tag_vld;
        end
    end

    // The search looks at the busy bits as they will be after this cycle.
    assign o_free         = gtsp_pkg::first_free(n_busy, i_pool_size);
    assign o_busy         = r_busy;
    assign o_tag_vld_next = n_tag_vld;

endmodule

`default_nettype wire

// File: design/gtsp_counters.sv
// ----------------------------------------------------------------------------
// gtsp_counters
// Live count, peak live count and the wrapping grant and reject counters.
// ----------------------------------------------------------------------------
`default_nettype none

module gtsp_counters (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire gtsp_pkg::t_slot_upd                   i_upd,
    output logic      [gtsp_pkg::BUSY_W-1:0]           o_busy_total,
    output logic      [gtsp_pkg::BUSY_W-1:0]           o_busy_peak,
    output logic      [gtsp_pkg::COUNT_WIDTH-1:0]      o_grant_count,
    output logic      [gtsp_pkg::COUNT_WIDTH-1:0]      o_reject_count
);

    logic [gtsp_pkg::BUSY_W-1:0]      r_busy_total;
    logic [gtsp_pkg::BUSY_W-1:0]      n_busy_total;
    logic [gtsp_pkg::BUSY_W-1:0]      r_busy_peak;
    logic [gtsp_pkg::COUNT_WIDTH-1:0] r_grant_count;
    logic [gtsp_pkg::COUNT_WIDTH-1:0] r_reject_count;

    // Live count follows grants and successful releases.
    always_comb begin
        n_busy_total = r_busy_total;
        if (i_upd.grant) begin
            n_busy_total = r_busy_total + gtsp_pkg::BUSY_W'(1);
        end else if (i_upd.release_ok && (r_busy_total != '0)) begin
            n_busy_total = r_busy_total - gtsp_pkg::BUSY_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_total   <= '0;
            r_busy_peak    <= '0;
            r_grant_count  <= '0;
            r_reject_count <= '0;
        end else begin
            r_busy_total <= n_busy_total;
            if (n_busy_total > r_busy_peak) begin
                r_busy_peak <= n_busy_total;
            end
            if (i_upd.grant) begin
                r_grant_count <= r_grant_count + gtsp_pkg::COUNT_WIDTH'(1);
            end
            if (i_upd.reject) begin
                r_reject_count <= r_reject_count + gtsp_pkg::COUNT_WIDTH'(1);
            end
        end
    end

    assign o_busy_total   = r_busy_total;
    assign o_busy_peak    = r_busy_peak;
    assign o_grant_count  = r_grant_count;
    assign o_reject_count = r_reject_count;

endmodule

`default_nettype wire

// File: design/generation_tagged_slot_pool.sv
// ----------------------------------------------------------------------------
// generation_tagged_slot_pool
// Allocator of generation-tagged handles from a fixed pool of slots.
// ----------------------------------------------------------------------------
// Usage:
// An input beat (i_in_valid high, o_in_stall low) carries an acquire or a
// release. An acquire takes the lowest free slot below the pool size and
// returns it with its new generation; a release frees a slot when the index
// is in range, the slot is held and the generation matches. Each input beat
// gives exactly one output beat (o_out_valid high, i_out_stall low) that also
// carries the live count, the peak and the grant and reject totals.
// The pool size is written on its own channel (i_cfg_valid, o_cfg_ready),
// which is always ready; write it only while no beat is in flight.
// A beat passes through the input register, which takes it together with the
// registered read of the tag RAM, and then through the result register. One
// beat per cycle is sustained while the receiver does not stall; the tag RAM
// read and the free-slot search both run while a beat is accepted and see the
// update of the beat being finished in that cycle. When the receiver stalls,
// the result holds and the input register stalls behind it once it is full.
// Reset clears all busy bits, tag-written bits and counters, so every tag
// reads as zero, and sets the pool size to 64.
// ----------------------------------------------------------------------------
`default_nettype none

module generation_tagged_slot_pool (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Configuration channel.
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [gtsp_pkg::POOL_W-1:0]          i_cfg_pool_size,
    // Input channel.
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic                                 i_op,
    input  wire logic [gtsp_pkg::IN_SLOT_W-1:0]       i_slot,
    input  wire logic [gtsp_pkg::IN_GEN_W-1:0]        i_generation,
    // Output channel.
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic      [1:0]                           o_status,
    output logic      [gtsp_pkg::OUT_SLOT_W-1:0]      o_granted_slot,
    output logic      [gtsp_pkg::OUT_GEN_W-1:0]       o_granted_generation,
    output logic      [gtsp_pkg::OUT_BUSY_W-1:0]      o_busy_count,
    output logic      [gtsp_pkg::OUT_BUSY_W-1:0]      o_peak_busy,
    output logic      [gtsp_pkg::OUT_COUNT_W-1:0]     o_grant_total,
    output logic      [gtsp_pkg::OUT_COUNT_W-1:0]     o_reject_total
);

    // Configuration register.
    logic [gtsp_pkg::POOL_W-1:0]    r_pool_size;

    // Input register.
    logic                           r_in_vld;
    gtsp_pkg::t_op                  r_op;
    logic [gtsp_pkg::SLOT_W-1:0]    r_idx;
    logic                           r_found;
    logic [gtsp_pkg::IN_GEN_W-1:0]  r_gen;
    logic                           r_tag_vld;
    logic                           r_byp;
    logic [gtsp_pkg::GEN_WIDTH-1:0] r_byp_data;

    // Result register.
    logic                            r_out_vld;
    gtsp_pkg::t_status               r_status;
    logic [gtsp_pkg::OUT_SLOT_W-1:0] r_gslot;
    logic [gtsp_pkg::OUT_GEN_W-1:0]  r_ggen;

    // Handshake and datapath signals.
    logic                           w_out_free;
    logic                           w_proc;
    logic                           w_accept;
    gtsp_pkg::t_op                  w_in_op;
    logic                           w_in_range;
    logic [gtsp_pkg::SLOT_W-1:0]    w_rd_addr;
    logic                           w_rd_found;
    logic [gtsp_pkg::GEN_WIDTH-1:0] w_ram_q;
    logic [gtsp_pkg::GEN_WIDTH-1:0] w_tag_cur;
    logic [gtsp_pkg::GEN_WIDTH-1:0] w_tag_new;
    logic                           w_tag_match;
    logic                           w_wr_en;
    gtsp_pkg::t_slot_upd            w_upd;
    logic [gtsp_pkg::SLOTS-1:0]     w_busy;
    logic [gtsp_pkg::SLOTS-1:0]     w_tag_vld_next;
    gtsp_pkg::t_free                w_free;
    logic [gtsp_pkg::BUSY_W-1:0]      w_busy_total;
    logic [gtsp_pkg::BUSY_W-1:0]      w_busy_peak;
    logic [gtsp_pkg::COUNT_WIDTH-1:0] w_grant_count;
    logic [gtsp_pkg::COUNT_WIDTH-1:0] w_reject_count;

    // Beat flow: the input register drains whenever the result register can take it.
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_proc     = r_in_vld && w_out_free;
    assign o_in_stall = r_in_vld && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Pool size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= gtsp_pkg::POOL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pool_size <= i_cfg_pool_size;
        end
    end

    // Tag address of the incoming beat: the free slot for an acquire, the
    // offered index for a release.
    assign w_in_op    = gtsp_pkg::t_op'(i_op);
    assign w_in_range = {1'b0, i_slot} < (gtsp_pkg::IN_SLOT_W + 1)'(gtsp_pkg::SLOTS);

    always_comb begin
        if (w_in_op == gtsp_pkg::OP_ACQUIRE) begin
            w_rd_addr  = w_free.idx;
            w_rd_found = w_free.found;
        end else begin
            w_rd_addr  = i_slot[gtsp_pkg::SLOT_W-1:0];
            w_rd_found = w_in_range;
        end
    end

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_proc) begin
            r_in_vld <= 1'b0;
        end
    end

    // Input register payload, with a bypass of a tag written in the same cycle.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= w_in_op;
            r_idx      <= w_rd_addr;
            r_found    <= w_rd_found;
            r_gen      <= i_generation;
            r_tag_vld  <= w_tag_vld_next[w_rd_addr];
            r_byp      <= w_wr_en && (w_upd.idx == w_rd_addr);
            r_byp_data <= w_tag_new;
        end
    end

    gtsp_ram #(
        .WIDTH (gtsp_pkg::GEN_WIDTH),
        .DEPTH (gtsp_pkg::SLOTS)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_upd.idx),
        .i_wr_data (w_tag_new),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_ram_q)
    );

    // Current tag of the slot in the input register.
    always_comb begin
        if (r_byp) begin
            w_tag_cur = r_byp_data;
        end else if (r_tag_vld) begin
            w_tag_cur = w_ram_q;
        end else begin
            w_tag_cur = '0;
        end
    end

    assign w_tag_new   = gtsp_pkg::next_tag(w_tag_cur);
    assign w_tag_match = gtsp_pkg::CMP_W'(w_tag_cur) == gtsp_pkg::CMP_W'(r_gen);

    // Outcome of the beat in the input register.
    always_comb begin
        w_upd            = '0;
        w_upd.idx        = r_idx;
        if (w_proc) begin
            if (r_op == gtsp_pkg::OP_ACQUIRE) begin
                w_upd.grant  = r_found;
                w_upd.reject = !r_found;
            end else begin
                w_upd.release_ok = r_found && w_busy[r_idx] && w_tag_match;
            end
        end
    end

    assign w_wr_en = w_upd.grant;

    gtsp_slot_map u_slot_map (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_upd          (w_upd),
        .i_pool_size    (r_pool_size),
        .o_busy         (w_busy),
        .o_tag_vld_next (w_tag_vld_next),
        .o_free         (w_free)
    );

    gtsp_counters u_counters (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_upd          (w_upd),
        .o_busy_total   (w_busy_total),
        .o_busy_peak    (w_busy_peak),
        .o_grant_count  (w_grant_count),
        .o_reject_count (w_reject_count)
    );

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_gslot <= '0;
            r_ggen  <= '0;
            if (w_upd.grant) begin
                r_status <= gtsp_pkg::ST_OK;
                r_gslot  <= gtsp_pkg::OUT_SLOT_W'(r_idx);
                r_ggen   <= gtsp_pkg::OUT_GEN_W'(w_tag_new);
            end else if (w_upd.reject) begin
                r_status <= gtsp_pkg::ST_FULL;
            end else if (w_upd.release_ok) begin
                r_status <= gtsp_pkg::ST_OK;
            end else begin
                r_status <= gtsp_pkg::ST_IGNORED;
            end
        end
    end

    // The counters change only when a beat enters the result register, so
    // they always belong to the result on show.
    assign o_out_valid          = r_out_vld;
    assign o_status             = r_status;
    assign o_granted_slot       = r_gslot;
    assign o_granted_generation = r_ggen;
    assign o_busy_count         = gtsp_pkg::OUT_BUSY_W'(w_busy_total);
    assign o_peak_busy          = gtsp_pkg::OUT_BUSY_W'(w_busy_peak);
    assign o_grant_total        = gtsp_pkg::OUT_COUNT_W'(w_grant_count);
    assign o_reject_total       = gtsp_pkg::OUT_COUNT_W'(w_reject_count);

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Slot pool testbench
// Drives acquire and release beats into the generation-tagged slot pool and
// predicts each result from a local copy of the busy bits, tags and counters.
// Directed cases cover bad and stale releases, the pool size limits and a
// pool shrunk under held slots. Random phases follow, with idle bursts on
// both channels and a final phase at full rate.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gtsp_pkg::*;

    // Expected contents of one result beat.
    typedef struct {
        t_status                 status;
        logic [OUT_SLOT_W-1:0]   slot;
        logic [OUT_GEN_W-1:0]    gen;
        logic [OUT_BUSY_W-1:0]   busy;
        logic [OUT_BUSY_W-1:0]   peak;
        logic [OUT_COUNT_W-1:0]  grants;
        logic [OUT_COUNT_W-1:0]  rejects;
    } pool_answer_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [POOL_W-1:0]        i_cfg_pool_size = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic                     i_op = 1'b0;
    logic [IN_SLOT_W-1:0]     i_slot = '0;
    logic [IN_GEN_W-1:0]      i_generation = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [1:0]               o_status;
    logic [OUT_SLOT_W-1:0]    o_granted_slot;
    logic [OUT_GEN_W-1:0]     o_granted_generation;
    logic [OUT_BUSY_W-1:0]    o_busy_count;
    logic [OUT_BUSY_W-1:0]    o_peak_busy;
    logic [OUT_COUNT_W-1:0]   o_grant_total;
    logic [OUT_COUNT_W-1:0]   o_reject_total;

    // Local copy of the pool state.
    logic [POOL_W-1:0]        pool_limit = POOL_RESET;
    logic                     slot_held [SLOTS];
    logic [GEN_WIDTH-1:0]     slot_gen [SLOTS];
    logic [OUT_BUSY_W-1:0]    live_count = '0;
    logic [OUT_BUSY_W-1:0]    live_peak = '0;
    logic [COUNT_WIDTH-1:0]   grants_seen = '0;
    logic [COUNT_WIDTH-1:0]   rejects_seen = '0;

    pool_answer_t             awaited_answers [$];
    int                       mismatch_count = 0;
    int                       stall_left = 0;
    logic                     quiet = 1'b0;

    generation_tagged_slot_pool dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_pool_size      (i_cfg_pool_size),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_op                 (i_op),
        .i_slot               (i_slot),
        .i_generation         (i_generation),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_status             (o_status),
        .o_granted_slot       (o_granted_slot),
        .o_granted_generation (o_granted_generation),
        .o_busy_count         (o_busy_count),
        .o_peak_busy          (o_peak_busy),
        .o_grant_total        (o_grant_total),
        .o_reject_total       (o_reject_total)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            slot_held[i] = 1'b0;
            slot_gen[i]  = '0;
        end
    end

    // Applies one beat to the local pool state and returns the result it
    // should produce.
    function automatic pool_answer_t predict_pool_answer(input t_op op,
                                                         input logic [IN_SLOT_W-1:0] idx,
                                                         input logic [IN_GEN_W-1:0] gen);
        pool_answer_t ans;
        int           usable;
        int           pick;
        logic [GEN_WIDTH-1:0] fresh;
        logic [SLOT_W-1:0]    sidx;
        ans.status = ST_OK;
        ans.slot   = '0;
        ans.gen    = '0;
        pick       = -1;
        sidx       = idx[SLOT_W-1:0];
        if (op == OP_ACQUIRE) begin
            // Sizes above the pool depth behave as the full pool.
            usable = (int'(pool_limit) > SLOTS) ? SLOTS : int'(pool_limit);
            for (int i = usable - 1; i >= 0; i--) begin
                if (!slot_held[i]) begin
                    pick = i;
                end
            end
            if (pick >= 0) begin
                fresh = slot_gen[pick] + 1'b1;
                if (fresh == '0) begin
                    fresh = GEN_WIDTH'(1);
                end
                slot_gen[pick]  = fresh;
                slot_held[pick] = 1'b1;
                live_count      = live_count + 1'b1;
                if (live_count > live_peak) begin
                    live_peak = live_count;
                end
                grants_seen = grants_seen + 1'b1;
                ans.slot    = OUT_SLOT_W'(pick);
                ans.gen     = OUT_GEN_W'(fresh);
            end else begin
                rejects_seen = rejects_seen + 1'b1;
                ans.status   = ST_FULL;
            end
        end else begin
            if (int'(idx) < SLOTS && slot_held[sidx] && slot_gen[sidx] == GEN_WIDTH'(gen)) begin
                slot_held[sidx] = 1'b0;
                if (live_count != 0) begin
                    live_count = live_count - 1'b1;
                end
            end else begin
                ans.status = ST_IGNORED;
            end
        end
        ans.busy    = live_count;
        ans.peak    = live_peak;
        ans.grants  = grants_seen;
        ans.rejects = rejects_seen;
        return ans;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    // Receiver: random stall bursts, and a check of every accepted result beat.
    always @(posedge i_clk) begin : result_monitor
        pool_answer_t want;
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 4);
        end else begin
            i_out_stall <= 1'b0;
        end

        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (awaited_answers.size() == 0) begin
                report_mismatch("result beat with no request outstanding");
            end else begin
                want = awaited_answers.pop_front();
                check_field("status", o_status, want.status);
                check_field("granted_slot", o_granted_slot, want.slot);
                check_field("granted_generation", o_granted_generation, want.gen);
                check_field("busy_count", o_busy_count, want.busy);
                check_field("peak_busy", o_peak_busy, want.peak);
                check_field("grant_total", o_grant_total, want.grants);
                check_field("reject_total", o_reject_total, want.rejects);
            end
        end
    end

    // Sends one beat, after an optional idle burst; valid stays high on
    // return so that back-to-back beats need no second assignment.
    task automatic send_request(input t_op op, input logic [IN_SLOT_W-1:0] idx,
                                input logic [IN_GEN_W-1:0] gen);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_slot       <= idx;
        i_generation <= gen;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        awaited_answers.push_back(predict_pool_answer(op, idx, gen));
    endtask

    // Lowers valid and waits for every outstanding result.
    task automatic settle_pool();
        i_in_valid <= 1'b0;
        while (awaited_answers.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_pool_size(input logic [POOL_W-1:0] size);
        settle_pool();
        i_cfg_valid     <= 1'b1;
        i_cfg_pool_size <= size;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pool_limit = size;
    endtask

    // Bad, stale and good releases against the reset pool size.
    task automatic test_release_checks();
        send_request(OP_ACQUIRE, 8'hFF, 32'hFFFF_FFFF);
        send_request(OP_ACQUIRE, 8'h00, 32'h0000_0000);
        send_request(OP_RELEASE, 8'd0, 32'h0000_0000);
        send_request(OP_RELEASE, 8'd0, 32'hFFFF_FFFF);
        send_request(OP_RELEASE, 8'(SLOTS), 32'd1);
        send_request(OP_RELEASE, 8'hFF, 32'd1);
        send_request(OP_RELEASE, 8'd0, slot_gen[0]);
        // Second release of the same handle finds the slot free.
        send_request(OP_RELEASE, 8'd0, slot_gen[0]);
        send_request(OP_ACQUIRE, 8'h5A, 32'hA5A5_A5A5);
        // The handle from before the re-acquire is stale.
        send_request(OP_RELEASE, 8'd0, slot_gen[0] - 1'b1);
        send_request(OP_RELEASE, 8'd1, slot_gen[1]);
        send_request(OP_RELEASE, 8'd0, slot_gen[0]);
    endtask

    // Pool size of one and zero, oversize, and a pool shrunk under held slots.
    task automatic test_pool_limits();
        write_pool_size(7'd1);
        send_request(OP_ACQUIRE, 8'd0, 32'd0);
        send_request(OP_ACQUIRE, 8'd0, 32'd0);
        write_pool_size(7'd0);
        send_request(OP_ACQUIRE, 8'd0, 32'd0);
        send_request(OP_RELEASE, 8'd0, slot_gen[0]);
        send_request(OP_ACQUIRE, 8'd0, 32'd0);
        write_pool_size(7'h7F);
        send_request(OP_ACQUIRE, 8'd0, 32'd0);
        send_request(OP_ACQUIRE, 8'd0, 32'd0);
        send_request(OP_ACQUIRE, 8'd0, 32'd0);
        write_pool_size(7'd1);
        send_request(OP_ACQUIRE, 8'd0, 32'd0);
        send_request(OP_RELEASE, 8'd2, slot_gen[2]);
        send_request(OP_RELEASE, 8'd0, slot_gen[0]);
        send_request(OP_ACQUIRE, 8'd0, 32'd0);
    endtask

    // Random mix: mostly acquires and releases of live handles, the rest
    // out-of-range, corrupted, stale or arbitrary releases.
    task automatic run_random_phase(input logic [POOL_W-1:0] size, input int count,
                                    input int acquire_pct);
        int                    roll;
        int                    live [$];
        logic [IN_SLOT_W-1:0]  idx;
        logic [IN_GEN_W-1:0]   gen;
        write_pool_size(size);
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            live.delete();
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_held[i]) begin
                    live.push_back(i);
                end
            end
            if (roll < acquire_pct) begin
                send_request(OP_ACQUIRE, IN_SLOT_W'($urandom), $urandom);
            end else if (live.size() != 0 && roll < 100 - (100 - acquire_pct) / 4) begin
                idx = IN_SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
                send_request(OP_RELEASE, idx, slot_gen[idx[SLOT_W-1:0]]);
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        idx = IN_SLOT_W'($urandom_range(SLOTS, 255));
                        gen = $urandom;
                    end
                    1: begin
                        idx = IN_SLOT_W'($urandom_range(0, SLOTS - 1));
                        gen = slot_gen[idx[SLOT_W-1:0]] ^ (32'd1 << $urandom_range(0, 31));
                    end
                    2: begin
                        idx = IN_SLOT_W'($urandom_range(0, SLOTS - 1));
                        gen = slot_gen[idx[SLOT_W-1:0]];
                    end
                    default: begin
                        idx = IN_SLOT_W'($urandom);
                        gen = $urandom;
                    end
                endcase
                send_request(OP_RELEASE, idx, gen);
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(7'd64, 150, 80);
        run_random_phase(7'h7F, 100, 40);
        run_random_phase(7'd5, 100, 60);
        run_random_phase(7'd0, 40, 50);
        run_random_phase(7'd33, 100, 50);
    endtask

    // Final stretch at full rate on both channels.
    task automatic test_full_rate();
        settle_pool();
        quiet = 1'b1;
        run_random_phase(7'd64, 110, 55);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_release_checks();
        test_pool_limits();
        test_random_traffic();
        test_full_rate();
        settle_pool();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
design/gtsp_pkg.sv
design/gtsp_ram.sv
design/gtsp_slot_map.sv
design/gtsp_counters.sv
design/generation_tagged_slot_pool.sv
tb/testbench.sv
